[rtl/crsl_pkg.sv]
// shared types and constants of the current reference slew limiter
package crsl_pkg;

	localparam int ACC_FRAC_DEFAULT = 10;
	localparam int ACC_W = 32;
	localparam int TARGET_W = 21;
	localparam int STEP_W = 16;
	localparam int MODE_W = 3;
	localparam int DUR_W = 20;
	localparam int RECIP_W = 32;
	localparam int CEIL_W = 21;
	localparam int POL_W = 2;
	localparam int REF_W = 20;
	localparam int IN_W = 120;
	localparam int OUT_W = 24;

	localparam logic [MODE_W-1:0] MODE_ZERO = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HOLD = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RISE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FALL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SAFETY = 3'd6;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_LOAD    = 10'b0000000010,
		ST_RATE    = 10'b0000000100,
		ST_MUL_A   = 10'b0000001000,
		ST_MUL_B   = 10'b0000010000,
		ST_FIX     = 10'b0000100000,
		ST_STEP    = 10'b0001000000,
		ST_ROUND   = 10'b0010000000,
		ST_CLAMP   = 10'b0100000000,
		ST_PUBLISH = 10'b1000000000
	} state_t;

	// one strobe per sequencer step
	typedef struct packed {
		logic ready;
		logic load;
		logic rate;
		logic mul_a;
		logic mul_b;
		logic fix;
		logic step;
		logic rnd;
		logic clamp;
		logic publish;
	} ctrl_t;

	typedef struct packed {
		logic take;
		logic need_mul;
		logic out_free;
	} stat_t;

endpackage

[rtl/crsl_mul.sv]
// shared 32 by 32 multiplier with registered product
module crsl_mul (
	input  logic                              clk,
	input  logic [crsl_pkg::ACC_W-1:0]        op_a,
	input  logic [crsl_pkg::ACC_W-1:0]        op_b,
	output logic [2*crsl_pkg::ACC_W-1:0]      prod_q
);
	import crsl_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= (2*ACC_W)'(op_a) * (2*ACC_W)'(op_b);
	end

endmodule

[rtl/crsl_seq.sv]
// sequencer that steps one item through the shared datapath
module crsl_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  crsl_pkg::stat_t stat,
	output crsl_pkg::ctrl_t ctrl
);
	import crsl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.take) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_RATE;
			ST_RATE: begin
				state_d = stat.need_mul ? ST_MUL_A : ST_STEP;
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_FIX;
			ST_FIX: state_d = ST_STEP;
			ST_STEP: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_PUBLISH;
			ST_PUBLISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctrl.ready = (state_q == ST_IDLE);
	assign ctrl.load = (state_q == ST_LOAD);
	assign ctrl.rate = (state_q == ST_RATE);
	assign ctrl.mul_a = (state_q == ST_MUL_A);
	assign ctrl.mul_b = (state_q == ST_MUL_B);
	assign ctrl.fix = (state_q == ST_FIX);
	assign ctrl.step = (state_q == ST_STEP);
	assign ctrl.rnd = (state_q == ST_ROUND);
	assign ctrl.clamp = (state_q == ST_CLAMP);
	assign ctrl.publish = (state_q == ST_PUBLISH);

endmodule

[rtl/current_reference_slew_limiter.sv]
// top level: held command, q-format accumulator, slew rate and published reference
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  one command item per control tick
//  m_*      out  m_tvalid/m_tready  one current reference item per tick
//
// an accepted item passes load, rate, step, round, clamp and publish on its way
// to the output register; to derive a release rate the reciprocal multiply and
// the quotient times duration multiply share one 32x32 multiplier, adding three
// extra steps with the correction; s_tready is high only while the sequencer is idle,
// so no item is taken until the last is published; the output register lets the
// next item in while a result waits, a full register holds the sequencer
// reset clears the sequencer, the held command (mode force zero), the
// accumulator, the rate and the output valid
module current_reference_slew_limiter #(
	parameter int ACCUMULATOR_FRACTION_BITS = crsl_pkg::ACC_FRAC_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// command_valid, target_current, step_size, action, release_duration,
	// release_reciprocal, current_ceiling, zero_policy_code, zero fill
	input  logic [crsl_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// current_reference, zero fill
	output logic [crsl_pkg::OUT_W-1:0] m_tdata
);
	import crsl_pkg::*;

	localparam int FRAC = ACCUMULATOR_FRACTION_BITS;
	localparam int IQ_W = ACC_W + 1 - FRAC;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);

	ctrl_t ctrl;
	stat_t stat;

	// captured item
	logic                       cmd_valid_q;
	logic signed [TARGET_W-1:0] cmd_target_q;
	logic [STEP_W-1:0]          cmd_step_q;
	logic [MODE_W-1:0]          cmd_mode_q;
	logic [DUR_W-1:0]           cmd_dur_q;
	logic [RECIP_W-1:0]         cmd_recip_q;
	logic signed [CEIL_W-1:0]   cmd_ceil_q;
	logic [POL_W-1:0]           cmd_pol_q;

	// held command and state
	logic signed [TARGET_W-1:0] held_target_q;
	logic [STEP_W-1:0]          held_step_q;
	logic [MODE_W-1:0]          held_mode_q;
	logic [DUR_W-1:0]           held_dur_q;
	logic [RECIP_W-1:0]         held_recip_q;
	logic signed [CEIL_W-1:0]   held_ceil_q;
	logic [POL_W-1:0]           held_pol_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    rate_q;
	logic                       changed_q;
	logic                       was_rel_q;
	logic                       contract_q;
	logic [ACC_W-1:0]           quot_q;
	logic signed [IQ_W-1:0]     iq_q;

	logic                       take;
	logic                       differs;
	logic signed [ACC_W-1:0]    tq;
	logic [ACC_W-1:0]           step_ext;
	logic [ACC_W-1:0]           dur_ext;
	logic [ACC_W-1:0]           rel_a;
	logic                       held_rel;
	logic                       rel_need;
	logic [ACC_W-1:0]           op_a;
	logic [ACC_W-1:0]           op_b;
	logic [2*ACC_W-1:0]         prod_q;
	logic [ACC_W-1:0]           rem;
	logic                       rem_ge;
	logic                       bump;
	logic [ACC_W-1:0]           quot_fix;
	logic [ACC_W-1:0]           quot_min;
	logic signed [ACC_W-1:0]    sum;
	logic signed [ACC_W-1:0]    sum_clip;
	logic signed [IQ_W-1:0]     rnd;
	logic signed [CEIL_W-1:0]   ceil_pos;
	logic signed [IQ_W-1:0]     ceil_iq;
	logic signed [ACC_W-1:0]    ceil_acc;
	logic                       out_free;

	// round half up, floor shift
	function automatic logic signed [IQ_W-1:0] round_half(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] x;
		x = (ACC_W+1)'(a) + (ACC_W+1)'(HALF);
		return IQ_W'(x >>> FRAC);
	endfunction

	crsl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	crsl_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign s_tready = ctrl.ready;
	assign take = s_tvalid && ctrl.ready;
	assign out_free = !m_tvalid || m_tready;

	assign differs = (cmd_target_q != held_target_q) || (cmd_step_q != held_step_q) ||
		(cmd_mode_q != held_mode_q) || (cmd_dur_q != held_dur_q) ||
		(cmd_recip_q != held_recip_q) || (cmd_ceil_q != held_ceil_q) ||
		(cmd_pol_q != held_pol_q);

	assign tq = ACC_W'(held_target_q) <<< FRAC;
	assign step_ext = ACC_W'(held_step_q);
	assign dur_ext = ACC_W'(held_dur_q);
	assign rel_a = (!acc_q[ACC_W-1] && (acc_q != '0)) ? acc_q : '0;
	assign held_rel = (held_mode_q == MODE_RELEASE) || (held_mode_q == MODE_SAFETY);
	assign rel_need = !was_rel_q || contract_q || !rate_q[ACC_W-1];

	assign stat.take = take;
	assign stat.out_free = out_free;
	assign stat.need_mul = changed_q && held_rel && rel_need && (rel_a != '0) &&
		(dur_ext > ACC_W'(1));

	// first pass: accumulator times reciprocal; second pass: quotient times duration
	assign op_a = ctrl.mul_b ? prod_q[2*ACC_W-1:ACC_W] : rel_a;
	assign op_b = ctrl.mul_b ? dur_ext : held_recip_q;

	// quotient correction, all wrapping at 32 bits
	assign rem = rel_a - prod_q[ACC_W-1:0];
	assign rem_ge = rem >= dur_ext;
	assign bump = rem_ge ? (rem != dur_ext) : (rem != '0);
	assign quot_fix = quot_q + ACC_W'(rem_ge) + ACC_W'(bump);
	assign quot_min = (quot_fix == '0) ? ACC_W'(1) : quot_fix;

	assign sum = acc_q + rate_q;
	always_comb begin
		sum_clip = sum;
		if (!rate_q[ACC_W-1] && (rate_q != '0) && (sum > tq)) sum_clip = tq;
		else if (rate_q[ACC_W-1] && (sum < tq)) sum_clip = tq;
	end

	assign rnd = round_half(acc_q);
	assign ceil_pos = held_ceil_q[CEIL_W-1] ? '0 : held_ceil_q;
	assign ceil_iq = IQ_W'(ceil_pos);
	assign ceil_acc = ACC_W'(ceil_pos) <<< FRAC;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_valid_q <= s_tdata[0];
			cmd_target_q <= s_tdata[21:1];
			cmd_step_q <= s_tdata[37:22];
			cmd_mode_q <= s_tdata[40:38];
			cmd_dur_q <= s_tdata[60:41];
			cmd_recip_q <= s_tdata[92:61];
			cmd_ceil_q <= s_tdata[113:93];
			cmd_pol_q <= s_tdata[115:114];
		end
		if (ctrl.mul_b) begin
			quot_q <= prod_q[2*ACC_W-1:ACC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_target_q <= '0;
			held_step_q <= '0;
			held_mode_q <= MODE_ZERO;
			held_dur_q <= '0;
			held_recip_q <= '0;
			held_ceil_q <= '0;
			held_pol_q <= '0;
			acc_q <= '0;
			rate_q <= '0;
			changed_q <= 1'b0;
			was_rel_q <= 1'b0;
			contract_q <= 1'b0;
			iq_q <= '0;
		end else begin
			priority if (ctrl.load) begin
				changed_q <= cmd_valid_q && differs;
				was_rel_q <= held_rel;
				contract_q <= (cmd_dur_q != held_dur_q) || (cmd_recip_q != held_recip_q);
				if (cmd_valid_q && differs) begin
					held_target_q <= cmd_target_q;
					held_step_q <= cmd_step_q;
					held_mode_q <= cmd_mode_q;
					held_dur_q <= cmd_dur_q;
					held_recip_q <= cmd_recip_q;
					held_ceil_q <= cmd_ceil_q;
					held_pol_q <= cmd_pol_q;
				end
			end else if (ctrl.rate) begin
				if (changed_q) begin
					if ((held_mode_q == MODE_RISE) || (held_mode_q == MODE_FALL)) begin
						if (tq == acc_q) rate_q <= '0;
						else if (tq > acc_q) rate_q <= step_ext;
						else rate_q <= ACC_W'(0) - step_ext;
					end else if (held_rel) begin
						// the multiply path sets the rate later
						if (rel_need) begin
							if ((rel_a == '0) || (dur_ext == '0)) rate_q <= '0;
							else if (dur_ext == ACC_W'(1)) rate_q <= ACC_W'(0) - rel_a;
						end
					end else begin
						rate_q <= '0;
					end
				end
			end else if (ctrl.fix) begin
				rate_q <= ACC_W'(0) - quot_min;
			end else if (ctrl.step) begin
				unique case (held_mode_q)
					MODE_BYPASS: begin
						acc_q <= tq;
						rate_q <= '0;
					end
					MODE_HOLD: rate_q <= '0;
					MODE_RISE, MODE_FALL: begin
						acc_q <= sum_clip;
						if (sum_clip == tq) rate_q <= '0;
					end
					MODE_RELEASE, MODE_SAFETY: acc_q <= sum;
					default: begin
						acc_q <= '0;
						rate_q <= '0;
					end
				endcase
			end else if (ctrl.rnd) begin
				unique case (held_mode_q)
					MODE_BYPASS: iq_q <= IQ_W'(held_target_q);
					MODE_HOLD: iq_q <= rnd;
					MODE_RISE, MODE_FALL: begin
						iq_q <= rnd;
						if ((held_target_q == '0) && (rnd == '0)) begin
							acc_q <= '0;
							rate_q <= '0;
						end
					end
					MODE_RELEASE, MODE_SAFETY: begin
						// at or below zero, or rounding to zero: release is over
						if (acc_q < HALF) begin
							acc_q <= '0;
							rate_q <= '0;
							iq_q <= '0;
						end else begin
							iq_q <= rnd;
						end
					end
					default: iq_q <= '0;
				endcase
			end else if (ctrl.clamp) begin
				if (iq_q[IQ_W-1]) begin
					iq_q <= '0;
					acc_q <= '0;
					rate_q <= '0;
				end else if (iq_q > ceil_iq) begin
					iq_q <= ceil_iq;
					acc_q <= ceil_acc;
					if (!rate_q[ACC_W-1] && (rate_q != '0)) rate_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.publish && out_free) begin
			m_tdata <= OUT_W'(iq_q[REF_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctrl.publish && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule

[test/current_reference_slew_limiter_tb.sv]
// self-checking testbench for the current reference slew limiter, directed table then random ticks
`timescale 1ns / 1ps

module current_reference_slew_limiter_tb;
	import crsl_pkg::*;

	localparam int FRAC = ACC_FRAC_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_TICKS = 470;
	localparam logic [MODE_W-1:0] MODE_ZERO_ALT = 3'd7;
	localparam logic signed [TARGET_W-1:0] COUNTS_MAX = 21'sd1048575;
	localparam logic signed [TARGET_W-1:0] COUNTS_MIN = -21'sd1048576;

	typedef struct {
		logic                       valid;
		logic signed [TARGET_W-1:0] target;
		logic [STEP_W-1:0]          step;
		logic [MODE_W-1:0]          action;
		logic [DUR_W-1:0]           dur;
		logic [RECIP_W-1:0]         recip;
		logic signed [CEIL_W-1:0]   ceil;
		logic [POL_W-1:0]           pol;
	} tick_cmd_t;

	typedef struct {
		tick_cmd_t        cmd;
		bit               typed;
		logic [REF_W-1:0] typed_value;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	current_reference_slew_limiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// predictor state, reset values
	int                         acc_q = 0;
	int                         rate_q = 0;
	logic signed [TARGET_W-1:0] h_target = '0;
	logic [STEP_W-1:0]          h_step = '0;
	logic [MODE_W-1:0]          h_mode = MODE_ZERO;
	logic [DUR_W-1:0]           h_dur = '0;
	logic [RECIP_W-1:0]         h_recip = '0;
	logic signed [CEIL_W-1:0]   h_ceil = '0;
	logic [POL_W-1:0]           h_pol = '0;

	logic [REF_W-1:0] expected_refs[$];
	tick_row_t directed_rows[$];
	tick_cmd_t current_cmd;
	int send_idle_pct = 27;
	int recv_idle_pct = 62;
	int ticks_sent = 0;
	int release_ticks = 0;
	int refs_checked = 0;
	int errors = 0;
	int cycles = 0;

	function automatic int scale_q(int counts);
		return counts <<< FRAC;
	endfunction

	// round half up, floor shift
	function automatic longint round_q(int acc);
		longint x;
		x = longint'(acc) + (longint'(1) <<< (FRAC - 1));
		return x >>> FRAC;
	endfunction

	// ceil(acc / duration) via reciprocal multiply and correction, wrapping at 32 bits
	function automatic int unsigned release_step(int unsigned a);
		int unsigned d, q, r;
		logic [63:0] p;
		d = 32'(h_dur);
		if (a == 0 || d == 0)
			return 0;
		if (d == 1)
			return a;
		p = 64'(a) * 64'(h_recip);
		q = p[63:32];
		r = a - q * d;
		if (r >= d) begin
			q++;
			r -= d;
		end
		if (r != 0)
			q++;
		return (q == 0) ? 1 : q;
	endfunction

	function automatic logic [REF_W-1:0] predict_reference(tick_cmd_t c);
		logic [MODE_W-1:0] old_mode;
		logic [DUR_W-1:0] prev_dur;
		logic [RECIP_W-1:0] prev_recip;
		bit chg, was_rel, contract;
		int tq, ceil_c;
		int unsigned a;
		longint iq;
		old_mode = h_mode;
		prev_dur = h_dur;
		prev_recip = h_recip;
		chg = 0;
		if (c.valid && (c.target != h_target || c.step != h_step || c.action != h_mode ||
				c.dur != h_dur || c.recip != h_recip || c.ceil != h_ceil ||
				c.pol != h_pol)) begin
			chg = 1;
			h_target = c.target;
			h_step = c.step;
			h_mode = c.action;
			h_dur = c.dur;
			h_recip = c.recip;
			h_ceil = c.ceil;
			h_pol = c.pol;
		end
		tq = scale_q(int'(h_target));
		if (chg) begin
			if (h_mode == MODE_RISE || h_mode == MODE_FALL) begin
				if (tq == acc_q)
					rate_q = 0;
				else
					rate_q = (tq > acc_q) ? int'(h_step) : -int'(h_step);
			end else if (h_mode == MODE_RELEASE || h_mode == MODE_SAFETY) begin
				was_rel = (old_mode == MODE_RELEASE || old_mode == MODE_SAFETY);
				contract = (prev_dur != h_dur || prev_recip != h_recip);
				// a running release keeps its rate unless the duration contract moves or its rate is not negative
				if (!was_rel || contract || rate_q >= 0) begin
					a = (acc_q > 0) ? acc_q : 0;
					rate_q = -int'(release_step(a));
				end
			end else begin
				rate_q = 0;
			end
		end
		case (h_mode)
			MODE_BYPASS: begin
				acc_q = tq;
				rate_q = 0;
				iq = h_target;
			end
			MODE_HOLD: begin
				rate_q = 0;
				iq = round_q(acc_q);
			end
			MODE_RISE, MODE_FALL: begin
				acc_q = acc_q + rate_q;
				if (rate_q > 0 && acc_q > tq)
					acc_q = tq;
				else if (rate_q < 0 && acc_q < tq)
					acc_q = tq;
				if (acc_q == tq)
					rate_q = 0;
				iq = round_q(acc_q);
				if (h_target == 0 && iq == 0) begin
					acc_q = 0;
					rate_q = 0;
				end
			end
			MODE_RELEASE, MODE_SAFETY: begin
				acc_q = acc_q + rate_q;
				if (acc_q <= 0 || round_q(acc_q) == 0) begin
					acc_q = 0;
					rate_q = 0;
					iq = 0;
				end else begin
					iq = round_q(acc_q);
				end
			end
			default: begin
				acc_q = 0;
				rate_q = 0;
				iq = 0;
			end
		endcase
		if (iq < 0) begin
			iq = 0;
			acc_q = 0;
			rate_q = 0;
		end
		ceil_c = (h_ceil < 0) ? 0 : int'(h_ceil);
		if (iq > ceil_c) begin
			iq = ceil_c;
			acc_q = scale_q(ceil_c);
			if (rate_q > 0)
				rate_q = 0;
		end
		return iq[REF_W-1:0];
	endfunction

	function automatic logic [RECIP_W-1:0] recip_of(logic [DUR_W-1:0] d);
		if (d <= 1)
			return '0;
		return 32'(64'h1_0000_0000 / d);
	endfunction

	function automatic logic signed [TARGET_W-1:0] rand_level();
		case ($urandom_range(7))
			0: return '0;
			1: return COUNTS_MAX;
			2: return COUNTS_MIN;
			3, 4: return TARGET_W'($urandom_range(2000));
			5: return TARGET_W'($urandom_range(200000));
			6: return -$signed(21'($urandom_range(2000)));
			default: return TARGET_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [CEIL_W-1:0] rand_ceiling();
		case ($urandom_range(5))
			0: return CEIL_W'($urandom);
			1: return CEIL_W'($urandom_range(60000));
			default: return COUNTS_MAX;
		endcase
	endfunction

	function automatic tick_cmd_t rand_cmd();
		tick_cmd_t c;
		c.valid = 1'($urandom_range(1));
		c.target = TARGET_W'($urandom);
		c.step = STEP_W'($urandom);
		c.action = MODE_W'($urandom);
		c.dur = DUR_W'($urandom);
		c.recip = $urandom;
		c.ceil = CEIL_W'($urandom);
		c.pol = POL_W'($urandom);
		return c;
	endfunction

	task automatic send_cmd(input tick_cmd_t c, input bit typed, input logic [REF_W-1:0] typed_val);
		logic [REF_W-1:0] predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, c.pol, c.ceil, c.recip, c.dur, c.action, c.step, c.target, c.valid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_reference(c);
		expected_refs.push_back(typed ? typed_val : predicted);
		ticks_sent++;
		if (h_mode == MODE_RELEASE || h_mode == MODE_SAFETY)
			release_ticks++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_refs.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input logic v, input int tgt, input int stp, input logic [MODE_W-1:0] act,
			input int dur, input logic [RECIP_W-1:0] rcp, input int cl, input int pl,
			input bit typed, input int typed_val);
		tick_row_t r;
		r.cmd.valid = v;
		r.cmd.target = TARGET_W'(tgt);
		r.cmd.step = STEP_W'(stp);
		r.cmd.action = act;
		r.cmd.dur = DUR_W'(dur);
		r.cmd.recip = rcp;
		r.cmd.ceil = CEIL_W'(cl);
		r.cmd.pol = POL_W'(pl);
		r.typed = typed;
		r.typed_value = REF_W'(typed_val);
		directed_rows.push_back(r);
	endtask

	// repeat the running command, with garbage invalid items and the odd field tweak
	task automatic run_ticks(input int n);
		tick_cmd_t junk;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(7) == 0) begin
				current_cmd.valid = 1'b1;
				junk = rand_cmd();
				junk.valid = 1'b0;
				send_cmd(junk, 0, '0);
			end else begin
				if ($urandom_range(15) == 0) begin
					case ($urandom_range(3))
						0: current_cmd.pol = POL_W'($urandom);
						1: current_cmd.ceil = rand_ceiling();
						2: current_cmd.step = STEP_W'($urandom);
						default: begin
							current_cmd.dur = DUR_W'(current_cmd.dur + 1);
							current_cmd.recip = recip_of(current_cmd.dur);
						end
					endcase
				end
				send_cmd(current_cmd, 0, '0);
			end
		end
	endtask

	task automatic run_sequence();
		int n;
		if ($urandom_range(29) == 0)
			hold_until_drained();
		current_cmd.valid = 1'b1;
		case ($urandom_range(5))
			0, 1: begin
				current_cmd.action = MODE_BYPASS;
				current_cmd.target = rand_level();
				current_cmd.ceil = rand_ceiling();
				current_cmd.pol = POL_W'($urandom);
				send_cmd(current_cmd, 0, '0);
				current_cmd.action = $urandom_range(1) ? MODE_RISE : MODE_FALL;
				current_cmd.target = rand_level();
				current_cmd.step = STEP_W'($urandom_range(1) ? $urandom_range(65535) :
					$urandom_range(3000));
				run_ticks($urandom_range(4, 40));
			end
			2, 3: begin
				current_cmd.action = MODE_BYPASS;
				current_cmd.target = $urandom_range(1) ? TARGET_W'($urandom_range(100000)) :
					rand_level();
				current_cmd.ceil = rand_ceiling();
				send_cmd(current_cmd, 0, '0);
				current_cmd.action = $urandom_range(1) ? MODE_RELEASE : MODE_SAFETY;
				current_cmd.target = TARGET_W'($urandom);
				current_cmd.dur = DUR_W'(($urandom_range(9) < 7) ? $urandom_range(40) : $urandom);
				current_cmd.recip = ($urandom_range(5) == 0) ? $urandom : recip_of(current_cmd.dur);
				n = int'(current_cmd.dur) + 3;
				run_ticks((n > 50 || n < 0) ? 50 : n);
			end
			4: begin
				case ($urandom_range(3))
					0: current_cmd.action = MODE_ZERO;
					1: current_cmd.action = MODE_HOLD;
					2: current_cmd.action = MODE_BYPASS;
					default: current_cmd.action = MODE_ZERO_ALT;
				endcase
				current_cmd.target = rand_level();
				run_ticks($urandom_range(1, 6));
			end
			default: begin
				n = $urandom_range(2, 8);
				for (int i = 0; i < n; i++)
					send_cmd(rand_cmd(), 0, '0);
			end
		endcase
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_refs.size() == 0) begin
				$display("%0t unexpected item current_reference expected none got %0d",
					$time, m_tdata[REF_W-1:0]);
				errors++;
			end else begin
				if (m_tdata[REF_W-1:0] !== expected_refs[0]) begin
					$display("%0t mismatch current_reference expected %0d got %0d",
						$time, expected_refs[0], m_tdata[REF_W-1:0]);
					errors++;
				end
				void'(expected_refs.pop_front());
				refs_checked++;
			end
		end
	end

	initial begin
		int directed_count;
		int phase_end;
		// after reset and the plain extremes
		add_row(0, 0, 0, MODE_ZERO, 0, 0, 0, 0, 1, 0);
		add_row(1, 1000, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 1000);
		add_row(1, 1000, 0, MODE_HOLD, 0, 0, COUNTS_MAX, 0, 1, 1000);
		// invalid command keeps the held hold
		add_row(0, -5, 65535, MODE_ZERO, 1048575, 32'hFFFFFFFF, COUNTS_MIN, 3, 1, 1000);
		add_row(1, 2000, 65535, MODE_RISE, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, 2000, 65535, MODE_RISE, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, 2000, 65535, MODE_RISE, 0, 0, COUNTS_MAX, 1, 0, 0);
		add_row(1, 0, 300, MODE_FALL, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, COUNTS_MIN, 65535, MODE_FALL, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, COUNTS_MAX, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 1048575);
		add_row(1, COUNTS_MAX, 0, MODE_BYPASS, 0, 0, 1234, 0, 1, 1234);
		add_row(1, 50000, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 50000);
		// zero duration, then a proper release and a policy change that keeps the rate
		add_row(1, 0, 0, MODE_RELEASE, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, 0, 0, MODE_RELEASE, 100, 42949672, COUNTS_MAX, 0, 0, 0);
		add_row(1, 0, 0, MODE_RELEASE, 100, 42949672, COUNTS_MAX, 2, 0, 0);
		add_row(1, 0, 0, MODE_SAFETY, 100, 42949672, COUNTS_MAX, 2, 0, 0);
		// reciprocal that does not match the duration
		add_row(1, 0, 0, MODE_SAFETY, 1000, 32'hFFFFFFFF, COUNTS_MAX, 2, 0, 0);
		add_row(1, 0, 0, MODE_RELEASE, 1, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, COUNTS_MAX, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 1048575);
		add_row(1, 7, 9, MODE_ZERO_ALT, 0, 0, COUNTS_MAX, 0, 1, 0);
		add_row(1, COUNTS_MIN, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 0);
		add_row(1, 500, 0, MODE_BYPASS, 0, 0, COUNTS_MIN, 0, 1, 0);
		add_row(1, 500, 0, MODE_BYPASS, 0, 0, COUNTS_MAX, 0, 1, 500);
		add_row(1, 900, 0, MODE_RISE, 0, 0, COUNTS_MAX, 0, 0, 0);
		add_row(1, 0, 0, MODE_ZERO, 0, 0, COUNTS_MAX, 0, 1, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].typed_value);
		directed_count = ticks_sent;

		current_cmd = rand_cmd();
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 62;
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_end = ticks_sent + PHASE_TICKS;
			while (ticks_sent < phase_end)
				run_sequence();
			hold_until_drained();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d ticks, %0d from the directed table, %0d in release or safety",
			ticks_sent, directed_count, release_ticks);
		$display("%0d current references checked under three idle patterns, %0d errors",
			refs_checked, errors);
		if (errors == 0 && expected_refs.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
rtl/crsl_pkg.sv
rtl/crsl_mul.sv
rtl/crsl_seq.sv
rtl/current_reference_slew_limiter.sv
test/current_reference_slew_limiter_tb.sv
